// ===== rtl/core/hcfs_pkg.sv =====
// ----------------------------------------------------------------------------
// Hill-climb focus search package
// Shared widths, constants, register codes and payload types of the block.
// ----------------------------------------------------------------------------
package hcfs_pkg;

  // Sharpness metric grouping and pass limits.
  localparam int GROUP_SIZE = 5;
  localparam int MAX_PASS   = 100;

  // Field widths.
  localparam int STAT_W     = 32;
  localparam int QUOT_W     = 26;
  localparam int SUM_W      = QUOT_W + $clog2(GROUP_SIZE);
  localparam int CNT_W      = $clog2(GROUP_SIZE);
  localparam int PASS_W     = 7;
  localparam int STEP_W     = 8;
  localparam int STEPS_W    = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Depth of the metric queue between the front and back halves.
  localparam int QUEUE_DEPTH = 2;

  // Division of a 32-bit word by 100 as a multiply by the reciprocal.
  localparam logic [STAT_W-1:0] STAT_DIV_MAGIC = 32'h51EB851F;
  localparam int                STAT_DIV_SHIFT = 37;

  // Division of the trimmed group sum by the number of kept values.
  localparam int TRIM_DIV     = GROUP_SIZE - 2;
  localparam int TRIM_L       = $clog2(TRIM_DIV);
  localparam int TRIM_SHIFT   = SUM_W + TRIM_L;
  localparam int TRIM_MAGIC_W = SUM_W + 1;
  localparam logic [TRIM_MAGIC_W-1:0] TRIM_MAGIC =
    TRIM_MAGIC_W'((64'd1 << TRIM_SHIFT) / TRIM_DIV + 1);

  // Register reset values.
  localparam logic [PASS_W-1:0] PASS_LENGTH_RST = 7'd50;
  localparam logic [STEP_W-1:0] STEP_SIZE_RST   = 8'd6;
  localparam logic [PASS_W-1:0] DROP_LIMIT_RST  = 7'd5;
  localparam logic              SEARCH_DIR_RST  = 1'b0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PASS_LENGTH = 2'd0,
    CFG_STEP_SIZE   = 2'd1,
    CFG_DROP_LIMIT  = 2'd2,
    CFG_SEARCH_DIR  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [PASS_W-1:0] pass_length;
    logic [STEP_W-1:0] step_size;
    logic [PASS_W-1:0] drop_limit;
    logic              search_direction;
  } cfg_t;

  typedef struct packed {
    logic               move_dir;
    logic [STEPS_W-1:0] move_steps;
    logic               is_return;
    logic [QUOT_W-1:0]  metric_value;
    logic [QUOT_W-1:0]  peak_value;
  } move_t;

endpackage

// ===== rtl/core/hcfs_if.sv =====
// ----------------------------------------------------------------------------
// Hill-climb focus search channels
// Valid/ready channels for statistic words, move commands and register writes.
// ----------------------------------------------------------------------------
interface hcfs_stat_if import hcfs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] raw_statistic;

  modport source (output valid, output raw_statistic, input ready);
  modport sink   (input valid, input raw_statistic, output ready);
endinterface

interface hcfs_move_if import hcfs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               move_dir;
  logic [STEPS_W-1:0] move_steps;
  logic               is_return;
  logic [QUOT_W-1:0]  metric_value;
  logic [QUOT_W-1:0]  peak_value;

  modport source (output valid, output move_dir, output move_steps, output is_return,
                  output metric_value, output peak_value, input ready);
  modport sink   (input valid, input move_dir, input move_steps, input is_return,
                  input metric_value, input peak_value, output ready);
endinterface

interface hcfs_cfg_if import hcfs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/hcfs_front.sv =====
// ----------------------------------------------------------------------------
// Hill-climb focus search front end
// Scales statistic words, gathers groups and forms the trimmed mean metric.
// ----------------------------------------------------------------------------
module hcfs_front import hcfs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  hcfs_stat_if.sink         stat_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output logic [QUOT_W-1:0] push_metric_o
);

  logic                    s1_valid_q, s1_valid_d;
  logic [QUOT_W-1:0]       s1_quot_q;
  logic                    s2_valid_q, s2_valid_d;
  logic [SUM_W-1:0]        s2_trim_q;
  logic [CNT_W-1:0]        grp_cnt_q, grp_cnt_d;
  logic [SUM_W-1:0]        grp_sum_q, sum_n;
  logic [QUOT_W-1:0]       grp_max_q, grp_min_q, max_n, min_n;
  logic [2*STAT_W-1:0]     div_prod;
  logic [SUM_W+TRIM_MAGIC_W-1:0] trim_prod;
  logic                    stat_acc, s1_take, grp_first, grp_done;
  logic [SUM_W-1:0]        trim_n;

  // Stage one: word divided by 100.
  assign div_prod = {{STAT_W{1'b0}}, stat_i.raw_statistic} * {{STAT_W{1'b0}}, STAT_DIV_MAGIC};

  assign s1_take      = s1_valid_q && (!s2_valid_q || push_ready_i);
  assign stat_i.ready = !s1_valid_q || s1_take;
  assign stat_acc     = stat_i.valid && stat_i.ready;

  // Stage two: group accumulation with running maximum and minimum.
  assign grp_first = (grp_cnt_q == '0);
  assign grp_done  = (grp_cnt_q == CNT_W'(GROUP_SIZE - 1));
  assign max_n     = (grp_first || s1_quot_q > grp_max_q) ? s1_quot_q : grp_max_q;
  assign min_n     = (grp_first || s1_quot_q < grp_min_q) ? s1_quot_q : grp_min_q;
  assign sum_n     = grp_first ? SUM_W'(s1_quot_q) : grp_sum_q + SUM_W'(s1_quot_q);
  assign trim_n    = sum_n - SUM_W'(max_n) - SUM_W'(min_n);

  always_comb begin
    grp_cnt_d = grp_cnt_q;
    if (s1_take) begin
      grp_cnt_d = grp_done ? '0 : grp_cnt_q + CNT_W'(1);
    end
  end

  assign s1_valid_d = stat_acc || (s1_valid_q && !s1_take);
  assign s2_valid_d = (s2_valid_q && !push_ready_i) || (s1_take && grp_done);

  // The queue write takes the trimmed sum divided by the kept count.
  assign trim_prod     = {{TRIM_MAGIC_W{1'b0}}, s2_trim_q} * {{SUM_W{1'b0}}, TRIM_MAGIC};
  assign push_valid_o  = s2_valid_q;
  assign push_metric_o = trim_prod[TRIM_SHIFT +: QUOT_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      grp_cnt_q  <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
      grp_cnt_q  <= grp_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat_acc) begin
      s1_quot_q <= div_prod[STAT_DIV_SHIFT +: QUOT_W];
    end
    if (s1_take) begin
      grp_sum_q <= sum_n;
      grp_max_q <= max_n;
      grp_min_q <= min_n;
    end
    if (s1_take && grp_done) begin
      s2_trim_q <= trim_n;
    end
  end

endmodule

// ===== rtl/core/hcfs_queue.sv =====
// ----------------------------------------------------------------------------
// Hill-climb focus search metric queue
// Short first-in first-out buffer between the front and back halves.
// ----------------------------------------------------------------------------
module hcfs_queue import hcfs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  logic [QUOT_W-1:0] push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output logic [QUOT_W-1:0] pop_data_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [QUOT_W-1:0] mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q;
  logic              push, pop;

  assign push_ready_o = (count_q != CNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/core/hcfs_back.sv =====
// ----------------------------------------------------------------------------
// Hill-climb focus search back end
// Tracks the pass peak and drops, and issues step and return moves.
// ----------------------------------------------------------------------------
module hcfs_back import hcfs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              pop_valid_i,
  output logic              pop_ready_o,
  input  logic [QUOT_W-1:0] pop_metric_i,
  hcfs_move_if.source       move_o
);

  logic              out_valid_q, ret_valid_q;
  move_t             out_q, ret_q, step_mv, ret_mv;
  logic [PASS_W-1:0] pass_idx_q, peak_idx_q, drop_q;
  logic [QUOT_W-1:0] peak_q;
  logic [PASS_W-1:0] peak_idx_n, drop_n, limit;
  logic [QUOT_W-1:0] peak_n;
  logic [PASS_W:0]   taken, span;
  logic [STEP_W+PASS_W:0] ret_prod;
  logic              out_adv, pop, pass_end;

  assign out_adv     = !out_valid_q || move_o.ready;
  assign pop_ready_o = !ret_valid_q && out_adv;
  assign pop         = pop_valid_i && pop_ready_o;

  always_comb begin
    peak_n     = peak_q;
    peak_idx_n = peak_idx_q;
    if (pass_idx_q == '0) begin
      peak_n     = pop_metric_i;
      peak_idx_n = '0;
    end else if (pop_metric_i > peak_q) begin
      peak_n     = pop_metric_i;
      peak_idx_n = pass_idx_q;
    end
    drop_n = drop_q;
    if (pop_metric_i < peak_n && drop_q != '1) begin
      drop_n = drop_q + PASS_W'(1);
    end
    if (cfg_i.pass_length > PASS_W'(MAX_PASS)) begin
      limit = PASS_W'(MAX_PASS);
    end else if (cfg_i.pass_length == '0) begin
      limit = PASS_W'(1);
    end else begin
      limit = cfg_i.pass_length;
    end
  end

  assign taken    = {1'b0, pass_idx_q} + (PASS_W+1)'(1);
  assign span     = taken - {1'b0, peak_idx_n};
  assign ret_prod = {{(PASS_W+1){1'b0}}, cfg_i.step_size} * {{STEP_W{1'b0}}, span};
  assign pass_end = (drop_n >= cfg_i.drop_limit) || (taken >= {1'b0, limit});

  always_comb begin
    step_mv.move_dir     = cfg_i.search_direction;
    step_mv.move_steps   = {{(STEPS_W-STEP_W){1'b0}}, cfg_i.step_size};
    step_mv.is_return    = 1'b0;
    step_mv.metric_value = pop_metric_i;
    step_mv.peak_value   = peak_n;
    ret_mv               = step_mv;
    ret_mv.move_dir      = !cfg_i.search_direction;
    ret_mv.move_steps    = ret_prod[STEPS_W-1:0];
    ret_mv.is_return     = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      ret_valid_q <= 1'b0;
      pass_idx_q  <= '0;
      peak_q      <= '0;
      peak_idx_q  <= '0;
      drop_q      <= '0;
    end else begin
      if (ret_valid_q && out_adv) begin
        out_valid_q <= 1'b1;
        ret_valid_q <= 1'b0;
      end else if (pop) begin
        out_valid_q <= 1'b1;
        ret_valid_q <= pass_end;
      end else if (move_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (pop) begin
        if (pass_end) begin
          pass_idx_q <= '0;
          peak_q     <= '0;
          peak_idx_q <= '0;
          drop_q     <= '0;
        end else begin
          pass_idx_q <= taken[PASS_W-1:0];
          peak_q     <= peak_n;
          peak_idx_q <= peak_idx_n;
          drop_q     <= drop_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ret_valid_q && out_adv) begin
      out_q <= ret_q;
    end else if (pop) begin
      out_q <= step_mv;
      ret_q <= ret_mv;
    end
  end

  assign move_o.valid        = out_valid_q;
  assign move_o.move_dir     = out_q.move_dir;
  assign move_o.move_steps   = out_q.move_steps;
  assign move_o.is_return    = out_q.is_return;
  assign move_o.metric_value = out_q.metric_value;
  assign move_o.peak_value   = out_q.peak_value;

endmodule

// ===== rtl/core/hill_climb_focus_search_top.sv =====
// ----------------------------------------------------------------------------
// Hill-climb focus search
// Contrast autofocus search that turns statistic words into motor moves.
// ----------------------------------------------------------------------------
// Usage. Statistic words enter on stat_i, one item per accepted handshake, and
// a new word can be taken in every cycle unless a full queue holds back the
// front. Each word is scaled down by 100 and every five words form one
// sharpness metric (trimmed mean). Every metric yields one step move on move_o;
// when the pass ends on the drop limit or the pass length, a second item follows
// with is_return set, moving back to the peak in the opposite direction.
// The step move for a metric passes the stage-one and trim registers, the queue
// and the output register after the word that completes its group is accepted;
// the return move follows once the step is taken. The front pipeline (divide,
// group, trim) and the back end (peak tracking, move issue) are decoupled by a
// two-entry metric queue, so input words keep flowing while the output waits.
// A stalled receiver eventually fills the queue and stat_i.ready falls.
// Registers are written on cfg_i, whose ready is always high; writes should be
// made while the block is idle and take effect from the next metric.
// Reset clears the group, the pass state and the metric queue, and loads the
// register defaults: pass length 50, step size 6, drop limit 5, forward.
// ----------------------------------------------------------------------------
module hill_climb_focus_search_top import hcfs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  hcfs_stat_if.sink   stat_i,
  hcfs_cfg_if.sink    cfg_i,
  hcfs_move_if.source move_o
);

  cfg_t              cfg_q;
  logic              push_valid, push_ready, pop_valid, pop_ready;
  logic [QUOT_W-1:0] push_metric, pop_metric;

  // Register file: index selects the field, data is truncated to its width.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pass_length      <= PASS_LENGTH_RST;
      cfg_q.step_size        <= STEP_SIZE_RST;
      cfg_q.drop_limit       <= DROP_LIMIT_RST;
      cfg_q.search_direction <= SEARCH_DIR_RST;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_PASS_LENGTH: cfg_q.pass_length      <= cfg_i.data[PASS_W-1:0];
        CFG_STEP_SIZE:   cfg_q.step_size        <= cfg_i.data[STEP_W-1:0];
        CFG_DROP_LIMIT:  cfg_q.drop_limit       <= cfg_i.data[PASS_W-1:0];
        CFG_SEARCH_DIR:  cfg_q.search_direction <= cfg_i.data[0];
        default: begin
        end
      endcase
    end
  end

  // Front: scaling, grouping and metric formation.
  hcfs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stat_i        (stat_i),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_metric_o (push_metric)
  );

  // Metric queue so that each half can stall on its own.
  hcfs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_metric),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_metric)
  );

  // Back: peak search and move issue, with the output register.
  hcfs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_metric_i (pop_metric),
    .move_o       (move_o)
  );

endmodule
